// ===== rtl/core/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdc_pkg: shared types and constants
// Sizes, controller states, the command/status groups and the prefix match function of the compressor.
// ----------------------------------------------------------------------------
`default_nettype none
package gdc_pkg;

   localparam int ENTRY_BYTES = 8;
   localparam int ENTRY_W     = ENTRY_BYTES * 8;
   localparam int SLOT_W      = 8;
   localparam int DEPTH_W     = 5;
   localparam int ADDR_W      = SLOT_W + DEPTH_W;
   localparam int DICT_DEPTH  = 1 << ADDR_W;
   localparam int GROUP_W     = 4;
   localparam int SCAN_W      = GROUP_W + DEPTH_W;
   localparam int LEN_W       = 4;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_EMIT
   } gdc_state_type;

   typedef struct packed {
      logic init_step;
      logic load;
      logic start;
      logic scan;
      logic write;
   } gdc_cmd_type;

   typedef struct packed {
      logic init_done;
      logic go;
      logic scan_last;
      logic more;
   } gdc_status_type;

   function automatic logic [LEN_W-1:0] prefix_len(
      input logic [ENTRY_W-1:0] entry,
      input logic [ENTRY_W-1:0] look,
      input logic [LEN_W-1:0]   avail
   );
      logic [LEN_W-1:0] n;
      logic             run;
      n   = '0;
      run = 1'b1;
      for (int i = 0; i < ENTRY_BYTES; i++) begin
         if (run && (LEN_W'(i) < avail) &&
             ((entry[i*8 +: 8] == 8'd0) || (entry[i*8 +: 8] == look[i*8 +: 8]))) begin
            n = n + 1'b1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gdc_req_if.sv =====
// ----------------------------------------------------------------------------
// gdc_req_if: input byte channel
// Valid/ready channel carrying one text byte and its last flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface gdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gdc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gdc_rsp_if: token channel
// Valid/ready channel carrying one match token per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface gdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] slot_index;
   logic [4:0] entry_depth;
   logic [3:0] match_length;
   logic       run_end;

   modport source (output valid, output slot_index, output entry_depth,
                   output match_length, output run_end, input ready);
   modport sink   (input valid, input slot_index, input entry_depth,
                   input match_length, input run_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/grouped_dictionary_compressor_top.sv =====
// ----------------------------------------------------------------------------
// grouped_dictionary_compressor_top: streaming grouped dictionary compressor
// Buffers bytes, searches a 16-slot group at all depths, emits match tokens.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  req_chan  in   data_byte, last_byte
//  rsp_chan  out  slot_index, entry_depth, match_length, run_end
//
//  After reset the dictionary is seeded while req_chan.ready is low.
//  A byte that triggers no token is taken without leaving the idle state.
//  Each token is built in steps: start, 512 reads of the group, one a cycle
//  through the single RAM read port, then compare drain, write-back and emit;
//  a flush repeats these steps for each token.
//  The block holds while a token beat waits on rsp_chan.ready.
// ----------------------------------------------------------------------------
`default_nettype none
module grouped_dictionary_compressor_top import gdc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   gdc_req_if.sink   req_chan,
   gdc_rsp_if.source rsp_chan
);

   gdc_cmd_type    cmd;
   gdc_status_type status;

   gdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gdc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .data_byte    (req_chan.data_byte),
      .last_byte    (req_chan.last_byte),
      .slot_index   (rsp_chan.slot_index),
      .entry_depth  (rsp_chan.entry_depth),
      .match_length (rsp_chan.match_length),
      .run_end      (rsp_chan.run_end)
   );

endmodule
`default_nettype wire

// ===== rtl/core/gdc_ram.sv =====
// ----------------------------------------------------------------------------
// gdc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module gdc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/gdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdc_ctrl: compressor sequencer
// Steps through table init, byte intake, search scan, write-back and emit.
// ----------------------------------------------------------------------------
`default_nettype none
module gdc_ctrl import gdc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire gdc_status_type status,
   output gdc_cmd_type         cmd
);

   gdc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:  if (status.init_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid && status.go) state_in = ST_START;
         ST_START: state_in = ST_SCAN;
         ST_SCAN:  if (status.scan_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_EMIT;
         ST_EMIT:  if (rsp_ready) state_in = status.more ? ST_START : ST_IDLE;
         default:  state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_INIT:  cmd.init_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_START: cmd.start = 1'b1;
         ST_SCAN:  cmd.scan  = 1'b1;
         ST_DRAIN: ;
         ST_WRITE: cmd.write = 1'b1;
         ST_EMIT:  rsp_valid = 1'b1;
         default:  ;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/gdc_dp.sv =====
// ----------------------------------------------------------------------------
// gdc_dp: compressor datapath
// Lookahead buffer, dictionary RAM, scan counter, best-match tracking, token.
// ----------------------------------------------------------------------------
`default_nettype none
module gdc_dp import gdc_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire gdc_cmd_type      cmd,
   output gdc_status_type        status,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   output logic [SLOT_W-1:0]     slot_index,
   output logic [DEPTH_W-1:0]    entry_depth,
   output logic [LEN_W-1:0]      match_length,
   output logic                  run_end
);

   logic [ENTRY_BYTES-1:0][7:0] look_ff, look_in;
   logic [LEN_W-1:0]            cnt_ff, cnt_in;
   logic                        flush_ff;
   logic [ADDR_W-1:0]           init_ff;
   logic [SCAN_W-1:0]           scan_ff;
   logic                        rd_vld_ff;
   logic [SCAN_W-1:0]           rd_idx_ff;
   logic [LEN_W-1:0]            best_len_ff;
   logic [SLOT_W-1:0]           best_slot_ff;
   logic [DEPTH_W-1:0]          best_depth_ff;
   logic [ENTRY_W-1:0]          best_data_ff;
   logic [SLOT_W-1:0]           slot_ff;
   logic [DEPTH_W-1:0]          depth_ff;
   logic [LEN_W-1:0]            len_ff;
   logic                        end_ff;

   logic [ENTRY_W-1:0]          rdata;
   logic [ENTRY_W-1:0]          wdata;
   logic [ENTRY_W-1:0]          merged;
   logic [ENTRY_W-1:0]          init_word;
   logic [ADDR_W-1:0]           waddr;
   logic [ADDR_W-1:0]           raddr;
   logic                        we;
   logic [LEN_W-1:0]            cand_len;
   logic [LEN_W-1:0]            take_len;
   logic [LEN_W-1:0]            cnt_after;
   logic [LEN_W:0]              src;

   // seed: slot s with low nibble zero, depth d < 16 holds {d, s[7:4]} in byte 0
   always_comb begin
      init_word = '0;
      if ((init_ff[DEPTH_W +: GROUP_W] == '0) && !init_ff[DEPTH_W-1]) begin
         init_word[7:0] = {init_ff[GROUP_W-1:0], init_ff[ADDR_W-1 -: GROUP_W]};
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRY_BYTES; i++) begin
         if ((LEN_W'(i) < best_len_ff) && (best_data_ff[i*8 +: 8] == 8'd0)) begin
            merged[i*8 +: 8] = look_ff[i];
         end else begin
            merged[i*8 +: 8] = best_data_ff[i*8 +: 8];
         end
      end
   end

   assign take_len  = (best_len_ff == '0) ? LEN_W'(1) : best_len_ff;
   assign cnt_after = cnt_ff - take_len;
   assign raddr     = {look_ff[0][GROUP_W-1:0], scan_ff};
   assign we        = cmd.init_step || (cmd.write && (best_len_ff != '0));
   assign waddr     = cmd.init_step ? init_ff : {best_slot_ff, best_depth_ff};
   assign wdata     = cmd.init_step ? init_word : merged;
   assign cand_len  = prefix_len(rdata, look_ff, cnt_ff);

   gdc_ram #(.WIDTH(ENTRY_W), .DEPTH(DICT_DEPTH)) u_dict (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      look_in = look_ff;
      cnt_in  = cnt_ff;
      src     = '0;
      if (cmd.load && (cnt_ff < LEN_W'(ENTRY_BYTES))) begin
         look_in[cnt_ff[LEN_W-2:0]] = data_byte;
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.write) begin
         cnt_in = cnt_after;
         for (int i = 0; i < ENTRY_BYTES; i++) begin
            src = (LEN_W+1)'(i) + {1'b0, take_len};
            if (src < (LEN_W+1)'(ENTRY_BYTES)) begin
               look_in[i] = look_ff[src[LEN_W-2:0]];
            end else begin
               look_in[i] = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff   <= '0;
         cnt_ff    <= '0;
         flush_ff  <= 1'b0;
         init_ff   <= '0;
         rd_vld_ff <= 1'b0;
         scan_ff   <= '0;
      end else begin
         look_ff   <= look_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= cmd.scan;
         if (cmd.init_step) init_ff <= init_ff + 1'b1;
         if (cmd.load) flush_ff <= last_byte;
         if (cmd.start) begin
            scan_ff <= '0;
         end else if (cmd.scan) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_ff;
      if (cmd.start) begin
         best_len_ff   <= '0;
         best_slot_ff  <= {look_ff[0][GROUP_W-1:0], {GROUP_W{1'b0}}};
         best_depth_ff <= '0;
      end else if (rd_vld_ff && (cand_len > best_len_ff)) begin
         best_len_ff   <= cand_len;
         best_slot_ff  <= {look_ff[0][GROUP_W-1:0], rd_idx_ff[SCAN_W-1 -: GROUP_W]};
         best_depth_ff <= rd_idx_ff[DEPTH_W-1:0];
         best_data_ff  <= rdata;
      end
      if (cmd.write) begin
         slot_ff  <= best_slot_ff;
         depth_ff <= best_depth_ff;
         len_ff   <= take_len;
         end_ff   <= !flush_ff || (cnt_after == '0);
      end
   end

   assign status.init_done = (init_ff == ADDR_W'(DICT_DEPTH - 1));
   assign status.go        = last_byte || (cnt_ff >= LEN_W'(ENTRY_BYTES - 1));
   assign status.scan_last = (scan_ff == {SCAN_W{1'b1}});
   assign status.more      = flush_ff && (cnt_ff != '0);

   assign slot_index   = slot_ff;
   assign entry_depth  = depth_ff;
   assign match_length = len_ff;
   assign run_end      = end_ff;

endmodule
`default_nettype wire

// ===== rtl/core/gdc_chk.sv =====
// ----------------------------------------------------------------------------
// gdc_chk: port-level checker
// Watches the channels of the compressor top level over time.
// ----------------------------------------------------------------------------
`default_nettype none
module gdc_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] match_length,
   input wire logic       run_end
);

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (match_length != 4'd0) && (match_length <= 4'd8))
      else $error("token length out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(match_length))
      else $error("token beat dropped while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("intake open while token pending");

   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !run_end |=> !req_ready)
      else $error("intake reopened before run end");

endmodule

bind grouped_dictionary_compressor_top gdc_chk u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .match_length (rsp_chan.match_length),
   .run_end      (rsp_chan.run_end)
);
`default_nettype wire
